FILE: rtl/scb_pkg.sv
// Shared types, constants and helpers for the SACK scoreboard.
package scb_pkg;

  localparam int unsigned MAX_SEGMENTS_DEF = 1024;

  localparam logic [31:0] WINDOW_RST  = 32'd0;
  localparam logic [15:0] SEGSIZE_RST = 16'd1460;
  localparam logic [7:0]  THRESH_RST  = 8'd3;

  // configuration register indexes
  localparam logic [1:0] REG_WINDOW  = 2'd0;
  localparam logic [1:0] REG_SEGSIZE = 2'd1;
  localparam logic [1:0] REG_THRESH  = 2'd2;

  // item modes
  localparam logic [2:0] MODE_CLEAR = 3'd0;
  localparam logic [2:0] MODE_ACK   = 3'd1;
  localparam logic [2:0] MODE_SACK  = 3'd2;
  localparam logic [2:0] MODE_LOSS  = 3'd3;
  localparam logic [2:0] MODE_PIPE  = 3'd4;

  typedef struct packed {
    logic [2:0]  mode;
    logic        ack_flag;
    logic [31:0] seq_first;
    logic [31:0] seq_second;
    logic [31:0] high_retx;
  } scb_in_t;

  typedef struct packed {
    logic        lost;
    logic [31:0] pipe_bytes;
    logic [31:0] next_segment;
    logic        done_res;
  } scb_out_t;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_CLR_START,
    OP_CLR_STEP,
    OP_DIV_AMS,
    OP_DIV_A,
    OP_DIV_B,
    OP_SK_INIT,
    OP_SK_REM,
    OP_SK_STEP,
    OP_SLOT_INIT,
    OP_ACK_WR,
    OP_ADV,
    OP_LQ_EV,
    OP_BK_INIT,
    OP_BK_EV,
    OP_MUL,
    OP_SAT,
    OP_NX_HIT,
    OP_OUT_LOAD
  } scb_op_t;

  typedef struct packed {
    scb_op_t op;
  } scb_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       ack;
    logic       sk_ok;
    logic       div_busy;
    logic       slot_ok;
    logic       acked_q;
    logic       sacked_q;
    logic       k_zero;
    logic       k_at_base;
    logic       w_ok;
    logic       ex_ok;
    logic       carry;
    logic       lq_hit;
    logic       found;
    logic       clr_last;
    logic       out_free;
    logic       cfg_clear;
  } scb_stat_t;

  // serial sequence compare: a before b
  function automatic logic seq_lt(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = b - a;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage

FILE: rtl/scb_div.sv
// Restoring divider, one quotient bit per cycle, 32-bit by 16-bit.
module scb_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [31:0] quo,
  output logic [15:0] rem
);
  logic [16:0] r;
  logic [5:0]  cnt;
  logic [16:0] shifted;
  logic        fits;

  assign shifted = {r[15:0], quo[31]};
  assign fits    = shifted >= {1'b0, divisor};
  assign rem     = r[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 6'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd32;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r   <= 17'd0;
      quo <= dividend;
    end else if (busy) begin
      r   <= fits ? (shifted - {1'b0, divisor}) : shifted;
      quo <= {quo[30:0], fits};
    end
  end
endmodule

FILE: rtl/scb_dp.sv
// Scoreboard datapath: config, bit stores, walk registers, divider, result register.
module scb_dp #(
  parameter int unsigned MAX_SEGMENTS = scb_pkg::MAX_SEGMENTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  scb_pkg::scb_cmd_t cmd,
  output scb_pkg::scb_stat_t stat,
  input  scb_pkg::scb_in_t  in_data,
  input  logic              out_stall,
  output logic              out_valid,
  output scb_pkg::scb_out_t out_data,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import scb_pkg::*;

  localparam int unsigned AW = $clog2(MAX_SEGMENTS);
  localparam int unsigned PW = AW + 2;
  localparam logic [AW:0] MAXK = (AW + 1)'(MAX_SEGMENTS);

  logic [31:0] window;
  logic [15:0] segsize;
  logic [7:0]  thresh;

  scb_in_t     item;
  logic [AW:0] k, kbase, clr_idx;
  logic [31:0] s, d, d0, dvd, nxt_r, pipe_r;
  logic [32:0] p;
  logic        rzero, prev_sk, has_nx, found, lost_r;
  logic [8:0]  lcnt;
  logic [PW-1:0] pcnt;
  logic [PW+15:0] prod;

  logic acked_mem  [MAX_SEGMENTS];
  logic sacked_mem [MAX_SEGMENTS];
  logic acked_q, sacked_q;

  logic        div_start, div_busy, div_dec;
  logic [31:0] div_in, div_arg, dv_quo;
  logic [15:0] dv_rem;

  logic [32:0] seg33, d_sum;
  logic [31:0] span, seg32;
  logic        ex_ok, w_ok, slot_ok, lost_k, s_le_hr;
  logic [8:0]  lcnt_new;
  logic [PW-1:0] pc_inc;
  logic [63:0] prod64;
  logic        cfg_clear;

  // slot lookups divide (seq - 1); the sack walk divides its offset as is
  assign div_arg = div_dec ? (div_in - 32'd1) : div_in;

  scb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_arg),
    .divisor  (segsize),
    .busy     (div_busy),
    .quo      (dv_quo),
    .rem      (dv_rem)
  );

  assign seg32    = {16'd0, segsize};
  assign seg33    = {17'd0, segsize};
  assign d_sum    = {1'b0, d} + seg33;
  assign span     = item.seq_second - item.seq_first;
  assign ex_ok    = (k < MAXK) && (p < {1'b0, window});
  assign w_ok     = ex_ok && seq_lt(s, item.seq_second);
  assign slot_ok  = (segsize != 16'd0) && (dvd != 32'd0) && (dv_rem == 16'd0)
                 && (dv_quo < 32'(MAX_SEGMENTS)) && (dvd < window);
  assign lcnt_new = (lcnt == 9'd256) ? lcnt : lcnt + {8'd0, sacked_q};
  assign lost_k   = !acked_q && !sacked_q &&
                    ((thresh == 8'd0) ? (has_nx && !prev_sk) : (lcnt >= {1'b0, thresh}));
  assign s_le_hr  = (s == item.high_retx) || seq_lt(s, item.high_retx);
  assign pc_inc   = {{(PW-1){1'b0}}, !lost_k} + {{(PW-1){1'b0}}, s_le_hr};
  assign prod64   = 64'(prod);
  assign cfg_clear = cfg_valid && ((cfg_index == REG_WINDOW) || (cfg_index == REG_SEGSIZE));

  always_comb begin
    div_start = 1'b0;
    div_dec   = 1'b0;
    div_in    = item.seq_first;
    case (cmd.op)
      OP_DIV_AMS: begin
        div_start = 1'b1;
        div_dec   = 1'b1;
        div_in    = item.seq_first - seg32;
      end
      OP_DIV_A: begin
        div_start = 1'b1;
        div_dec   = 1'b1;
        div_in    = item.seq_first;
      end
      OP_DIV_B: begin
        div_start = 1'b1;
        div_dec   = 1'b1;
        div_in    = item.seq_second;
      end
      OP_SK_INIT: begin
        div_start = 1'b1;
        div_in    = 32'd1 - item.seq_first;
      end
      OP_SK_STEP: begin
        div_start = d_sum[32];
        div_in    = d_sum[31:0];
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    stat.mode      = item.mode;
    stat.ack       = item.ack_flag;
    stat.sk_ok     = (segsize != 16'd0) && (span != 32'd0) && !span[31];
    stat.div_busy  = div_busy;
    stat.slot_ok   = slot_ok;
    stat.acked_q   = acked_q;
    stat.sacked_q  = sacked_q;
    stat.k_zero    = (k == '0);
    stat.k_at_base = (k == kbase);
    stat.w_ok      = w_ok;
    stat.ex_ok     = ex_ok;
    stat.carry     = d_sum[32];
    stat.lq_hit    = (lcnt_new == {1'b0, thresh});
    stat.found     = found;
    stat.clr_last  = (clr_idx == MAXK - (AW + 1)'(1));
    stat.out_free  = !out_valid || !out_stall;
    stat.cfg_clear = cfg_clear;
  end

  // config registers, clear index, result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= WINDOW_RST;
      segsize   <= SEGSIZE_RST;
      thresh    <= THRESH_RST;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_WINDOW:  window  <= cfg_data;
          REG_SEGSIZE: segsize <= cfg_data[15:0];
          REG_THRESH:  thresh  <= cfg_data[7:0];
          default:     ;
        endcase
      end
      if (cfg_clear || cmd.op == OP_CLR_START) begin
        clr_idx <= '0;
      end else if (cmd.op == OP_CLR_STEP) begin
        clr_idx <= clr_idx + (AW + 1)'(1);
      end
      if (cmd.op == OP_OUT_LOAD) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // bit stores, registered read at the walk index
  always_ff @(posedge clk) begin
    acked_q  <= acked_mem[k[AW-1:0]];
    sacked_q <= sacked_mem[k[AW-1:0]];
    case (cmd.op)
      OP_CLR_STEP: begin
        acked_mem[clr_idx[AW-1:0]]  <= 1'b0;
        sacked_mem[clr_idx[AW-1:0]] <= 1'b0;
      end
      OP_ACK_WR: begin
        acked_mem[k[AW-1:0]] <= 1'b1;
      end
      OP_SK_STEP: begin
        if ((d < d0) && rzero) begin
          sacked_mem[k[AW-1:0]] <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (div_start) begin
      dvd <= div_in;
    end
    case (cmd.op)
      OP_LOAD: begin
        item   <= in_data;
        lost_r <= 1'b0;
        pipe_r <= 32'd0;
        nxt_r  <= 32'd0;
        found  <= 1'b0;
      end
      OP_SK_INIT: begin
        d  <= 32'd1 - item.seq_first;
        d0 <= span;
        k  <= '0;
        p  <= 33'd1;
      end
      OP_SK_REM: begin
        rzero <= (dv_rem == 16'd0);
      end
      OP_SK_STEP: begin
        k <= k + (AW + 1)'(1);
        p <= p + seg33;
        d <= d_sum[31:0];
      end
      OP_SLOT_INIT: begin
        k     <= dv_quo[AW:0];
        kbase <= dv_quo[AW:0];
        s     <= dvd;
        p     <= {1'b0, dvd};
        lcnt  <= 9'd0;
        pcnt  <= '0;
      end
      OP_ACK_WR: begin
        k <= k - (AW + 1)'(1);
      end
      OP_ADV: begin
        k <= k + (AW + 1)'(1);
        s <= s + seg32;
        p <= p + seg33;
      end
      OP_LQ_EV: begin
        lcnt   <= lcnt_new;
        lost_r <= stat.lq_hit;
        k      <= k + (AW + 1)'(1);
        s      <= s + seg32;
        p      <= p + seg33;
      end
      OP_BK_INIT: begin
        k       <= k - (AW + 1)'(1);
        s       <= s - seg32;
        lcnt    <= 9'd0;
        prev_sk <= 1'b0;
        has_nx  <= 1'b0;
      end
      OP_BK_EV: begin
        if (!sacked_q) begin
          pcnt <= pcnt + pc_inc;
        end
        if (seq_lt(item.high_retx, s) && lost_k) begin
          found <= 1'b1;
          nxt_r <= s;
        end
        lcnt    <= lcnt_new;
        prev_sk <= sacked_q;
        has_nx  <= 1'b1;
        if (k != kbase) begin
          k <= k - (AW + 1)'(1);
          s <= s - seg32;
        end
      end
      OP_MUL: begin
        prod <= (PW + 16)'(pcnt) * (PW + 16)'(segsize);
      end
      OP_SAT: begin
        pipe_r <= (|prod64[63:32]) ? 32'hFFFF_FFFF : prod64[31:0];
      end
      OP_NX_HIT: begin
        nxt_r <= s;
      end
      OP_OUT_LOAD: begin
        out_data.lost         <= lost_r;
        out_data.pipe_bytes   <= pipe_r;
        out_data.next_segment <= nxt_r;
        out_data.done_res     <= 1'b1;
      end
      default: ;
    endcase
  end
endmodule

FILE: rtl/scb_ctrl.sv
// Scoreboard controller: sequences clears, walks and divisions per item.
module scb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  scb_pkg::scb_stat_t stat,
  output scb_pkg::scb_cmd_t  cmd
);
  import scb_pkg::*;

  typedef enum logic [23:0] {
    S_CLR     = 24'h000001,
    S_IDLE    = 24'h000002,
    S_DECODE  = 24'h000004,
    S_DIV_ACK = 24'h000008,
    S_ACK_RD  = 24'h000010,
    S_ACK_EV  = 24'h000020,
    S_DIV_SK  = 24'h000040,
    S_SK_STEP = 24'h000080,
    S_DIV_LQ  = 24'h000100,
    S_LQ_RD0  = 24'h000200,
    S_LQ_EV0  = 24'h000400,
    S_LQ_CHK  = 24'h000800,
    S_LQ_EV   = 24'h001000,
    S_DIV_PH  = 24'h002000,
    S_PH_FWD  = 24'h004000,
    S_BK_RD   = 24'h008000,
    S_BK_EV   = 24'h010000,
    S_MUL     = 24'h020000,
    S_SAT     = 24'h040000,
    S_NX_GO   = 24'h080000,
    S_DIV_NX  = 24'h100000,
    S_NX_CHK  = 24'h200000,
    S_NX_EV   = 24'h400000,
    S_DONE    = 24'h800000
  } state_t;

  state_t state, state_next;
  logic   reply, reply_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    reply_next = reply;
    cmd.op     = OP_NOP;
    case (state)
      S_CLR: begin
        cmd.op = OP_CLR_STEP;
        if (stat.clr_last) begin
          state_next = reply ? S_DONE : S_IDLE;
          reply_next = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.mode)
          MODE_CLEAR: begin
            cmd.op     = OP_CLR_START;
            reply_next = 1'b1;
            state_next = S_CLR;
          end
          MODE_ACK: begin
            if (stat.ack) begin
              cmd.op     = OP_DIV_AMS;
              state_next = S_DIV_ACK;
            end else begin
              state_next = S_DONE;
            end
          end
          MODE_SACK: begin
            if (stat.ack && stat.sk_ok) begin
              cmd.op     = OP_SK_INIT;
              state_next = S_DIV_SK;
            end else begin
              state_next = S_DONE;
            end
          end
          MODE_LOSS: begin
            cmd.op     = OP_DIV_A;
            state_next = S_DIV_LQ;
          end
          MODE_PIPE: begin
            cmd.op     = OP_DIV_A;
            state_next = S_DIV_PH;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_DIV_ACK: begin
        if (!stat.div_busy) begin
          if (stat.slot_ok) begin
            cmd.op     = OP_SLOT_INIT;
            state_next = S_ACK_RD;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_ACK_RD: state_next = S_ACK_EV;
      S_ACK_EV: begin
        if (stat.acked_q) begin
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_ACK_WR;
          state_next = stat.k_zero ? S_DONE : S_ACK_RD;
        end
      end
      S_DIV_SK: begin
        if (!stat.div_busy) begin
          cmd.op     = OP_SK_REM;
          state_next = S_SK_STEP;
        end
      end
      S_SK_STEP: begin
        if (stat.ex_ok) begin
          cmd.op     = OP_SK_STEP;
          state_next = stat.carry ? S_DIV_SK : S_SK_STEP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV_LQ: begin
        if (!stat.div_busy) begin
          if (stat.slot_ok) begin
            cmd.op     = OP_SLOT_INIT;
            state_next = S_LQ_RD0;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_LQ_RD0: state_next = S_LQ_EV0;
      S_LQ_EV0: begin
        if (stat.acked_q || stat.sacked_q) begin
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_ADV;
          state_next = S_LQ_CHK;
        end
      end
      S_LQ_CHK: state_next = stat.w_ok ? S_LQ_EV : S_DONE;
      S_LQ_EV: begin
        cmd.op     = OP_LQ_EV;
        state_next = stat.lq_hit ? S_DONE : S_LQ_CHK;
      end
      S_DIV_PH: begin
        if (!stat.div_busy) begin
          if (stat.slot_ok) begin
            cmd.op     = OP_SLOT_INIT;
            state_next = S_PH_FWD;
          end else begin
            cmd.op     = OP_DIV_B;
            state_next = S_DIV_NX;
          end
        end
      end
      S_PH_FWD: begin
        if (stat.w_ok) begin
          cmd.op = OP_ADV;
        end else if (stat.k_at_base) begin
          state_next = S_MUL;
        end else begin
          cmd.op     = OP_BK_INIT;
          state_next = S_BK_RD;
        end
      end
      S_BK_RD: state_next = S_BK_EV;
      S_BK_EV: begin
        cmd.op     = OP_BK_EV;
        state_next = stat.k_at_base ? S_MUL : S_BK_RD;
      end
      S_MUL: begin
        cmd.op     = OP_MUL;
        state_next = S_SAT;
      end
      S_SAT: begin
        cmd.op     = OP_SAT;
        state_next = stat.found ? S_DONE : S_NX_GO;
      end
      S_NX_GO: begin
        cmd.op     = OP_DIV_B;
        state_next = S_DIV_NX;
      end
      S_DIV_NX: begin
        if (!stat.div_busy) begin
          if (stat.slot_ok) begin
            cmd.op     = OP_SLOT_INIT;
            state_next = S_NX_CHK;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_NX_CHK: state_next = stat.ex_ok ? S_NX_EV : S_DONE;
      S_NX_EV: begin
        if (!stat.acked_q && !stat.sacked_q) begin
          cmd.op     = OP_NX_HIT;
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_ADV;
          state_next = S_NX_CHK;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op     = OP_OUT_LOAD;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    // a window or segment size write restarts the clearing pass
    if (stat.cfg_clear) begin
      state_next = S_CLR;
      reply_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      reply <= 1'b0;
    end else begin
      state <= state_next;
      reply <= reply_next;
    end
  end
endmodule

FILE: rtl/tcp_sack_scoreboard.sv
// TCP SACK scoreboard: acked/sacked bit per segment slot, ack/sack updates, loss and pipe queries.
//
// Slot k sits at sequence 1 + k*segment_size and exists while that sequence is below
// window_bytes and k < MAX_SEGMENTS. One item is in work at a time; a finished result
// waits in an output register while the next item is taken. The ack, SACK, loss and
// pipe items use the shared bit-serial slot divider. A SACK block walks all existing
// slots and divides the running offset again when the walk passes the block start; a
// pipe query makes one forward pass, then a backward pass of read and evaluate, and a
// search past the transmit point when the next segment comes from there. The bit stores
// are read through a register at the walk index, which sets the walk speed. After
// reset and after every write of window_bytes or segment_size a clearing pass over all
// MAX_SEGMENTS slots runs, during which no item is taken; configuration writes are
// always accepted.
module tcp_sack_scoreboard #(
  parameter int unsigned MAX_SEGMENTS = scb_pkg::MAX_SEGMENTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  scb_pkg::scb_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output scb_pkg::scb_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import scb_pkg::*;

  scb_cmd_t  cmd;
  scb_stat_t stat;

  // configuration beats are taken in any cycle
  assign cfg_ready = 1'b1;

  scb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  scb_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // a window or segment size write blocks items while the stores clear
  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && (cfg_index == REG_WINDOW || cfg_index == REG_SEGSIZE)
    |=> in_stall)
    else $error("input not held off after store-clearing config write");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken before the first finished");

  // a result beat appears only at the end of an item's work
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result beat raised without an item in work");
endmodule
